// ----- hw/rtl/ssp_pkg.sv -----
package ssp_pkg;

  localparam int unsigned ValW = 64;
  localparam int unsigned ChW  = 8;
  localparam int unsigned CntW = 6;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChMinus = 8'h2D;
  localparam logic [ChW-1:0] ChX     = 8'h78;
  localparam logic [ChW-1:0] Ch0     = 8'h30;
  localparam logic [ChW-1:0] Ch9     = 8'h39;

  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] value;
  } ssp_scale_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } ssp_mul_sts_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_EMIT = 4'b1000
  } ssp_state_e;

  // 1000^n for n = 2..6; larger powers exceed 64 bits
  function automatic logic [ValW-1:0] pow1000(input logic [3:0] n);
    logic [ValW-1:0] r;
    case (n)
      4'd2:    r = 64'd1000000;
      4'd3:    r = 64'd1000000000;
      4'd4:    r = 64'd1000000000000;
      4'd5:    r = 64'd1000000000000000;
      4'd6:    r = 64'd1000000000000000000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic ssp_scale_t suffix_scale(input logic [1:0] len,
                                              input logic [23:0] chars);
    ssp_scale_t      s;
    logic [ChW-1:0]  c0, c1, c2;
    logic [3:0]      n;
    logic            is_k;
    c0 = chars[7:0];
    c1 = chars[15:8];
    c2 = chars[23:16];
    s.ok = 1'b0;
    s.value = '0;
    is_k = (c0 == "k") || (c0 == "K");
    case (c0)
      "M":     n = 4'd2;
      "G":     n = 4'd3;
      "T":     n = 4'd4;
      "P":     n = 4'd5;
      "E":     n = 4'd6;
      "Z":     n = 4'd7;
      "Y":     n = 4'd8;
      "R":     n = 4'd9;
      "Q":     n = 4'd10;
      default: n = 4'd0;
    endcase
    if (len == 2'd0) begin
      s.ok = 1'b1; s.value = 64'd1;
    end else if (len == 2'd1 && (c0 == "c" || c0 == "C" || c0 == "B")) begin
      s.ok = 1'b1; s.value = 64'd1;
    end else if (len == 2'd1 && (c0 == "w" || c0 == "W")) begin
      s.ok = 1'b1; s.value = 64'd2;
    end else if (len == 2'd1 && c0 == "b") begin
      s.ok = 1'b1; s.value = 64'd512;
    end else if (len == 2'd1 && is_k) begin
      s.ok = 1'b1; s.value = 64'd1024;
    end else if (len == 2'd3 && is_k && c1 == "i" && c2 == "B") begin
      s.ok = 1'b1; s.value = 64'd1024;
    end else if (len == 2'd2 && is_k && c1 == "B") begin
      s.ok = 1'b1; s.value = 64'd1000;
    end else if (n != 4'd0) begin
      if (len == 2'd1 || (len == 2'd3 && c1 == "i" && c2 == "B")) begin
        s.ok = (n <= 4'd6);
        s.value = s.ok ? (64'd1 << (7'd10 * 7'(n))) : '0;
      end else if (len == 2'd2 && c1 == "B") begin
        s.ok = (n <= 4'd6);
        s.value = pow1000(n);
      end
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/ssp_if.sv -----
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        ok;
  modport source (output valid, value, ok, input ready);
  modport sink   (input valid, value, ok, output ready);
endinterface

// ----- hw/rtl/ssp_mul.sv -----
module ssp_mul
  import ssp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] a_i,
  input  logic [ValW-1:0] b_i,
  output logic [ValW-1:0] prod_o,
  output ssp_mul_sts_t    sts_o
);

  // MSB-first shift-add, one multiplier bit per cycle; overflow is sticky
  logic [ValW-1:0] a_q, b_q, acc_q, acc_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, ovf_q, ovf_d, done_q;
  logic [ValW:0]   sum;

  always_comb begin
    sum   = {1'b0, acc_q[ValW-2:0], 1'b0} + {1'b0, (b_q[ValW-1] ? a_q : '0)};
    acc_d = sum[ValW-1:0];
    ovf_d = ovf_q | acc_q[ValW-1] | sum[ValW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
      end else if (busy_q) begin
        ovf_q <= ovf_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(ValW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[ValW-2:0], 1'b0};
    end
  end

  assign prod_o     = acc_q;
  assign sts_o.done = done_q;
  assign sts_o.ovf  = ovf_q;

endmodule

// ----- hw/rtl/size_string_parser_top.sv -----
// Size text parser, dd style: digits with optional suffix, factors joined
// by 'x' when allow_products is set, all checked for 64-bit overflow.
// Input channel in_i: one character per beat, last marks the final beat.
// Output channel out_o: one beat per text, after its last input beat, carrying
// value and ok (value is zero when ok is low).
// Config: cfg_we_i writes cfg_data_i into allow_products (reset value 1).
// Flow: a plain character keeps in_i.ready high. A beat closing a factor
// ('x', zero byte or last) runs two bit-serial multiplies on the shared
// shift-add unit (scale, then running product), and in_i.ready stays low
// until they finish; an overflow in the first skips the second.
// A last beat then passes the emit state, which loads the output register.
// A factor that fails early (no digits, bad suffix) skips the multiplies.
// in_i.ready is high only while the parser waits for a character.
// If out_o stalls, a finished result waits in the output register; the
// next text can be parsed meanwhile, and its own result holds until the
// register frees up.
// Reset: parse state clears, allow_products returns to 1, no beat pending.
module size_string_parser_top
  import ssp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  ssp_in_if.sink  in_i,
  ssp_out_if.source out_o,
  input  logic    cfg_we_i,
  input  logic    cfg_data_i
);

  ssp_state_e      state_q, state_d;
  logic            allow_q;

  // parse state
  logic [ValW-1:0] rp_q, rp_d;
  logic [ValW-1:0] fv_q, fv_d;
  logic            dnz_q, dnz_d;
  logic            insfx_q, insfx_d;
  logic [23:0]     sch_q, sch_d;
  logic [1:0]      slen_q, slen_d;
  logic            failed_q, failed_d;
  logic            ended_q, ended_d;
  logic            start_q, start_d;
  logic            lastp_q, lastp_d;

  // output register
  logic            ovalid_q, ovalid_d;
  logic [ValW-1:0] oval_q, oval_d;
  logic            ook_q, ook_d;

  // multiplier hookup
  logic            mstart;
  logic [ValW-1:0] ma, mb, mprod;
  ssp_mul_sts_t    msts;

  logic [ChW-1:0]  c;
  logic            accept, do_close, need_close, is_digit;
  logic [ValW+3:0] mac;
  ssp_scale_t      scl;

  assign c      = in_i.ch;
  assign accept = in_i.valid & in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign is_digit = (c >= Ch0) && (c <= Ch9);
  // fv*10 + d, overflow shows in the top bits
  assign mac = {1'b0, fv_q, 3'b000} + {3'b000, fv_q, 1'b0}
             + {{(ValW-4){1'b0}}, c - Ch0};

  always_comb begin
    state_d  = state_q;
    rp_d     = rp_q;
    fv_d     = fv_q;
    dnz_d    = dnz_q;
    insfx_d  = insfx_q;
    sch_d    = sch_q;
    slen_d   = slen_q;
    failed_d = failed_q;
    ended_d  = ended_q;
    start_d  = start_q;
    lastp_d  = lastp_q;
    ovalid_d = ovalid_q & ~out_o.ready;
    oval_d   = oval_q;
    ook_d    = ook_q;
    mstart   = 1'b0;
    ma       = fv_q;
    mb       = '0;
    do_close = 1'b0;
    need_close = 1'b0;
    scl      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!ended_q) begin
            if (c == ChNul) begin
              if (start_q) failed_d = 1'b1;
              do_close = 1'b1;
              ended_d  = 1'b1;
            end else begin
              start_d = 1'b0;
              if (!failed_q) begin
                if (start_q && c == ChMinus) begin
                  failed_d = 1'b1;
                end else if (c == ChX && allow_q) begin
                  do_close = 1'b1;
                end else if (!insfx_q && is_digit) begin
                  if (|mac[ValW+3:ValW]) failed_d = 1'b1;
                  else begin
                    fv_d  = mac[ValW-1:0];
                    dnz_d = 1'b1;
                  end
                end else begin
                  insfx_d = 1'b1;
                  if (slen_q == 2'd3) failed_d = 1'b1;
                  else begin
                    sch_d  = sch_q | (24'(c) << (5'd8 * slen_q));
                    slen_d = slen_q + 2'd1;
                  end
                end
              end
            end
          end
          need_close = do_close | (in_i.last & ~ended_d);
          // 'x' on the last beat: second close sees an empty factor
          if (do_close && in_i.last && !ended_d) failed_d = 1'b1;
          lastp_d = in_i.last;
          if (need_close) begin
            scl = suffix_scale(slen_d, sch_d);
            if (!failed_d && (!dnz_d || !scl.ok)) failed_d = 1'b1;
            if (!failed_d) begin
              mstart  = 1'b1;
              ma      = fv_d;
              mb      = scl.value;
              state_d = S_MUL1;
            end else if (in_i.last) begin
              state_d = S_EMIT;
            end
            fv_d    = '0;
            dnz_d   = 1'b0;
            insfx_d = 1'b0;
            sch_d   = '0;
            slen_d  = '0;
          end else if (in_i.last) begin
            state_d = S_EMIT;
          end
        end
      end
      S_MUL1: begin
        if (msts.done) begin
          if (msts.ovf) begin
            failed_d = 1'b1;
            state_d  = lastp_q ? S_EMIT : S_IDLE;
          end else begin
            mstart  = 1'b1;
            ma      = rp_q;
            mb      = mprod;
            state_d = S_MUL2;
          end
        end
      end
      S_MUL2: begin
        if (msts.done) begin
          if (msts.ovf) failed_d = 1'b1;
          else rp_d = mprod;
          state_d = lastp_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          oval_d   = failed_q ? '0 : rp_q;
          ook_d    = ~failed_q;
          rp_d     = 64'd1;
          fv_d     = '0;
          dnz_d    = 1'b0;
          insfx_d  = 1'b0;
          sch_d    = '0;
          slen_d   = '0;
          failed_d = 1'b0;
          ended_d  = 1'b0;
          start_d  = 1'b1;
          lastp_d  = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      allow_q  <= 1'b1;
      rp_q     <= 64'd1;
      fv_q     <= '0;
      dnz_q    <= 1'b0;
      insfx_q  <= 1'b0;
      sch_q    <= '0;
      slen_q   <= '0;
      failed_q <= 1'b0;
      ended_q  <= 1'b0;
      start_q  <= 1'b1;
      lastp_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) allow_q <= cfg_data_i;
      rp_q     <= rp_d;
      fv_q     <= fv_d;
      dnz_q    <= dnz_d;
      insfx_q  <= insfx_d;
      sch_q    <= sch_d;
      slen_q   <= slen_d;
      failed_q <= failed_d;
      ended_q  <= ended_d;
      start_q  <= start_d;
      lastp_q  <= lastp_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oval_q <= oval_d;
    ook_q  <= ook_d;
  end

  ssp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart),
    .a_i     (ma),
    .b_i     (mb),
    .prod_o  (mprod),
    .sts_o   (msts)
  );

  assign out_o.valid = ovalid_q;
  assign out_o.value = oval_q;
  assign out_o.ok    = ook_q;

`ifndef SYNTH
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ok |-> out_o.value == '0)
    else $error("failed result with nonzero value");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msts.done |-> (state_q == S_MUL1 || state_q == S_MUL2))
    else $error("multiply finished outside a multiply state");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && !ovalid_q |=> ovalid_q && state_q == S_IDLE)
    else $error("result not loaded from emit state");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mstart |-> (state_q == S_IDLE || msts.done))
    else $error("multiply started while busy");
`endif

endmodule
